[hw/rtl/uer_pkg.sv]
// Package for the ultrasonic echo ranger: shared types, register indexes and
// arithmetic constants. No dependencies.
`default_nettype none

package uer_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned UnitW    = 17;
  localparam int unsigned TickW    = 16;
  localparam int unsigned ScaleW   = 12;
  localparam int unsigned ProdW    = UnitW + ScaleW;
  localparam int unsigned DistW    = 8;

  // Register indexes on the configuration port.
  localparam logic [CfgIdxW-1:0] REG_PRESCALE = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_TRIGGER  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_WAIT     = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_ECHO     = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_SCALE    = 3'd4;

  localparam logic [15:0] PRESCALE_RST = 16'd64;
  localparam logic [7:0]  TRIGGER_RST  = 8'd20;
  localparam logic [15:0] WAIT_RST     = 16'd65000;
  localparam logic [15:0] ECHO_RST     = 16'd65535;
  localparam logic [11:0] SCALE_RST    = 12'd1088;

  localparam logic [UnitW-1:0] UNIT_MAX = '1;

  // Any product at or above 255 * 1000 + 1000 saturates the distance.
  localparam logic [ProdW-1:0] PROD_SAT = 29'd256000;
  // floor(x / 1000) = (x * RECIP_1000) >> RECIP_SHIFT for every x below 2^18.
  localparam int unsigned      QuotInW     = 18;
  localparam int unsigned      RecipW      = 19;
  localparam int unsigned      RECIP_SHIFT = 28;
  localparam logic [RecipW-1:0] RECIP_1000 = 19'd268436;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_ECHO = 2'd1,
    ST_OVERRUN = 2'd2
  } stat_e;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'b0001,
    PH_TRIG    = 4'b0010,
    PH_WAIT    = 4'b0100,
    PH_MEASURE = 4'b1000
  } phase_e;

  // Result of the control stage for one tick.
  typedef struct packed {
    logic              trig;
    logic              busy;
    logic              done;
    stat_e             stat;
    logic              calc;
    logic [UnitW-1:0]  unit;
    logic [ScaleW-1:0] scale;
  } ctrl_item_t;

  // Result of the multiply stage for one tick.
  typedef struct packed {
    logic             trig;
    logic             busy;
    logic             done;
    stat_e            stat;
    logic             calc;
    logic [ProdW-1:0] prod;
  } prod_item_t;

endpackage

`default_nettype wire

[hw/rtl/ultrasonic_echo_ranger.sv]
// Top level of the ultrasonic echo ranger: control, multiply and divide stages
// with their handshake. Depends on uer_pkg, uer_ctrl, uer_scale, uer_dist.
//
//  Channel   Direction  Contents
//  s_axis    in         one base tick: start request and echo level
//  m_axis    out        one result per tick: trigger, busy, done, distance, status
//  cfg       in         register writes, index 0..4, no read-back
//
// Each tick passes the ctrl, scale and dist registers; one per cycle unless m_axis stalls.
// The throughput is set by the sequencer, which updates its state once per accepted tick.
// The multiply and the divide by 1000 sit in the two stages after it.
// Reset loads register defaults and clears the sequencer, valid bits and last distance.
// A stalled output holds its request and fills the stages behind it before s_axis stalls.
`default_nettype none

module ultrasonic_echo_ranger import uer_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  wire logic [7:0]          s_axis_tdata_i,   // [0] start_req, [1] echo
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  output logic [15:0]              m_axis_tdata_o,   // [0] trigger, [1] busy_res,
                                                     // [2] done_res, [10:3] distance_cm,
                                                     // [12:11] status
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  logic va_q, vb_q, vc_q;
  logic en_a, en_b, en_c;
  logic accept;

  ctrl_item_t item_a;
  prod_item_t item_b;

  assign en_c   = !vc_q || m_axis_tready_i;
  assign en_b   = !vb_q || en_c;
  assign en_a   = !va_q || en_b;
  assign accept = en_a && s_axis_tvalid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (en_a) va_q <= s_axis_tvalid_i;
      if (en_b) vb_q <= va_q;
      if (en_c) vc_q <= vb_q;
    end
  end

  uer_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .start_req_i (s_axis_tdata_i[0]),
    .echo_i      (s_axis_tdata_i[1]),
    .item_o      (item_a)
  );

  uer_scale u_scale (
    .clk_i  (clk_i),
    .en_i   (en_b && va_q),
    .item_i (item_a),
    .item_o (item_b)
  );

  uer_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_c && vb_q),
    .item_i  (item_b),
    .tdata_o (m_axis_tdata_o)
  );

  assign s_axis_tready_o = en_a;
  assign m_axis_tvalid_o = vc_q;

endmodule

`default_nettype wire

[hw/rtl/uer_ctrl.sv]
// Measurement sequencer and configuration registers of the echo ranger.
// Depends on uer_pkg.
`default_nettype none

module uer_ctrl import uer_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                accept_i,
  input  wire logic                start_req_i,
  input  wire logic                echo_i,
  output ctrl_item_t               item_o
);

  logic [15:0] prescale_q;
  logic [7:0]  trigger_q;
  logic [15:0] wait_q;
  logic [15:0] echo_q;
  logic [11:0] scale_q;

  phase_e           phase_q, phase_d;
  logic [TickW-1:0] tick_q, tick_d;
  logic [UnitW-1:0] unit_q, unit_d;
  ctrl_item_t       item_q, item_d;

  logic [TickW:0]   tick_inc;
  logic [TickW-1:0] presc_eff;
  logic [7:0]       trig_eff;
  logic [UnitW-1:0] unit_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prescale_q <= PRESCALE_RST;
      trigger_q  <= TRIGGER_RST;
      wait_q     <= WAIT_RST;
      echo_q     <= ECHO_RST;
      scale_q    <= SCALE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PRESCALE: prescale_q <= cfg_data_i;
        REG_TRIGGER:  trigger_q  <= cfg_data_i[7:0];
        REG_WAIT:     wait_q     <= cfg_data_i;
        REG_ECHO:     echo_q     <= cfg_data_i;
        REG_SCALE:    scale_q    <= cfg_data_i[11:0];
        default:      ;
      endcase
    end
  end

  assign tick_inc  = {1'b0, tick_q} + 17'd1;
  assign presc_eff = (prescale_q == '0) ? 16'd1 : prescale_q;
  assign trig_eff  = (trigger_q == '0) ? 8'd1 : trigger_q;
  assign unit_inc  = (unit_q == UNIT_MAX) ? unit_q : unit_q + 17'd1;

  always_comb begin
    phase_d      = phase_q;
    tick_d       = tick_q;
    unit_d       = unit_q;
    item_d       = '0;
    item_d.stat  = ST_OK;
    item_d.unit  = unit_q;
    item_d.scale = scale_q;
    case (phase_q)
      PH_IDLE: begin
        if (start_req_i) begin
          item_d.busy = 1'b1;
          tick_d      = '0;
          unit_d      = '0;
          phase_d     = PH_TRIG;
        end
      end
      PH_TRIG: begin
        item_d.trig = 1'b1;
        item_d.busy = 1'b1;
        tick_d      = tick_inc[TickW-1:0];
        if (tick_inc[TickW-1:0] >= {8'd0, trig_eff}) begin
          tick_d  = '0;
          unit_d  = '0;
          phase_d = PH_WAIT;
        end
      end
      PH_WAIT: begin
        if (echo_i) begin
          item_d.busy = 1'b1;
          tick_d      = '0;
          unit_d      = '0;
          phase_d     = PH_MEASURE;
        end else if (unit_q > {1'b0, wait_q}) begin
          item_d.done = 1'b1;
          item_d.stat = ST_NO_ECHO;
          phase_d     = PH_IDLE;
        end else begin
          item_d.busy = 1'b1;
          if (tick_inc >= {1'b0, presc_eff}) begin
            tick_d = '0;
            unit_d = unit_inc;
          end else begin
            tick_d = tick_inc[TickW-1:0];
          end
        end
      end
      PH_MEASURE: begin
        if (!echo_i) begin
          item_d.done = 1'b1;
          item_d.calc = 1'b1;
          phase_d     = PH_IDLE;
        end else if (unit_q > {1'b0, echo_q}) begin
          item_d.done = 1'b1;
          item_d.stat = ST_OVERRUN;
          phase_d     = PH_IDLE;
        end else begin
          item_d.busy = 1'b1;
          if (tick_inc >= {1'b0, presc_eff}) begin
            tick_d = '0;
            unit_d = unit_inc;
          end else begin
            tick_d = tick_inc[TickW-1:0];
          end
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      tick_q  <= '0;
      unit_q  <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      unit_q  <= unit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      item_q <= item_d;
    end
  end

  assign item_o = item_q;

endmodule

`default_nettype wire

[hw/rtl/uer_scale.sv]
// Multiply stage: echo width in units times the scale register.
// Depends on uer_pkg.
`default_nettype none

module uer_scale import uer_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       en_i,
  input  wire ctrl_item_t item_i,
  output prod_item_t      item_o
);

  prod_item_t item_q, item_d;

  always_comb begin
    item_d.trig = item_i.trig;
    item_d.busy = item_i.busy;
    item_d.done = item_i.done;
    item_d.stat = item_i.stat;
    item_d.calc = item_i.calc;
    item_d.prod = ProdW'(item_i.unit) * ProdW'(item_i.scale);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign item_o = item_q;

endmodule

`default_nettype wire

[hw/rtl/uer_dist.sv]
// Divide by 1000 with saturation, last-distance hold and output register.
// Depends on uer_pkg.
`default_nettype none

module uer_dist import uer_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        en_i,
  input  wire prod_item_t  item_i,
  output logic [15:0]      tdata_o
);

  localparam int unsigned QuotFullW = QuotInW + RecipW;

  logic [DistW-1:0]     last_q;
  logic [DistW-1:0]     dist_cm;
  logic [DistW-1:0]     quot;
  logic [QuotFullW-1:0] quot_full;
  logic [15:0]          tdata_q, tdata_d;

  // The product is below 2^18 whenever it does not saturate.
  assign quot_full = QuotFullW'(item_i.prod[QuotInW-1:0]) * QuotFullW'(RECIP_1000);
  assign quot      = quot_full[RECIP_SHIFT +: DistW];

  always_comb begin
    dist_cm = last_q;
    if (item_i.done) begin
      if (!item_i.calc) begin
        dist_cm = '0;
      end else if (item_i.prod >= PROD_SAT) begin
        dist_cm = '1;
      end else begin
        dist_cm = quot;
      end
    end
    tdata_d = {3'b000, item_i.stat, dist_cm, item_i.done, item_i.busy, item_i.trig};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
    end else if (en_i) begin
      last_q <= dist_cm;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tdata_q <= tdata_d;
    end
  end

  assign tdata_o = tdata_q;

endmodule

`default_nettype wire

[hw/rtl/uer_checker.sv]
// Port-level checks of the echo ranger results, bound to the top level.
// Depends on uer_pkg and ultrasonic_echo_ranger.
`default_nettype none

module uer_checker import uer_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [15:0] m_axis_tdata_o
);

  logic  trig, busy, done;
  stat_e stat;
  logic [7:0] dist_cm;

  assign trig    = m_axis_tdata_o[0];
  assign busy    = m_axis_tdata_o[1];
  assign done    = m_axis_tdata_o[2];
  assign dist_cm = m_axis_tdata_o[10:3];
  assign stat    = stat_e'(m_axis_tdata_o[12:11]);

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && done |-> !busy)
    else $error("done reported while busy");

  a_trig_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && trig |-> busy && !done)
    else $error("trigger high outside a measurement");

  a_stat_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && stat != ST_OK |-> done)
    else $error("error status without done");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && done && (stat == ST_NO_ECHO || stat == ST_OVERRUN) |-> dist_cm == 8'd0)
    else $error("failed measurement with nonzero distance");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

`default_nettype wire
